// ===== rtl/fpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes, error codes, shared types and saturation helpers.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int DATA_W    = 32;
   localparam int MODE_W    = 4;
   localparam int ERR_W     = 2;
   localparam int WIDE_W    = 48;
   localparam int DIV_STEPS = 4;
   localparam int FRAC_BITS_DEFAULT = 8;

   localparam logic [MODE_W-1:0] MODE_ADD     = 4'd0;
   localparam logic [MODE_W-1:0] MODE_SUB     = 4'd1;
   localparam logic [MODE_W-1:0] MODE_MUL     = 4'd2;
   localparam logic [MODE_W-1:0] MODE_DIV     = 4'd3;
   localparam logic [MODE_W-1:0] MODE_LT      = 4'd4;
   localparam logic [MODE_W-1:0] MODE_GT      = 4'd5;
   localparam logic [MODE_W-1:0] MODE_LE      = 4'd6;
   localparam logic [MODE_W-1:0] MODE_GE      = 4'd7;
   localparam logic [MODE_W-1:0] MODE_NE      = 4'd8;
   localparam logic [MODE_W-1:0] MODE_MIN     = 4'd9;
   localparam logic [MODE_W-1:0] MODE_MAX     = 4'd10;
   localparam logic [MODE_W-1:0] MODE_INC     = 4'd11;
   localparam logic [MODE_W-1:0] MODE_DEC     = 4'd12;
   localparam logic [MODE_W-1:0] MODE_TOINT   = 4'd13;
   localparam logic [MODE_W-1:0] MODE_FROMINT = 4'd14;

   localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVF  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_DIV0 = 2'd2;

   localparam logic [DATA_W-1:0] S32_MAX = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
   localparam logic signed [WIDE_W-1:0] WIDE_MAX = 48'sd2147483647;
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = -48'sd2147483648;

   typedef struct packed {
      logic              ovf;
      logic [DATA_W-1:0] value;
   } sat_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] simple_value;
      logic              simple_ovf;
      logic              compare_true;
      logic [63:0]       prod_mag;
      logic              prod_neg;
      logic              div_zero;
   } op_type;

   typedef struct packed {
      logic [ERR_W-1:0]  error_code;
      logic              compare_true;
      logic [DATA_W-1:0] result_value;
   } result_type;

   function automatic sat_type sat_wide(input logic signed [WIDE_W-1:0] v);
      sat_type r;
      if (v > WIDE_MAX) begin
         r.ovf   = 1'b1;
         r.value = S32_MAX;
      end else if (v < WIDE_MIN) begin
         r.ovf   = 1'b1;
         r.value = S32_MIN;
      end else begin
         r.ovf   = 1'b0;
         r.value = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic sat_type sat_mag(input logic [63:0] m, input logic neg);
      sat_type r;
      if (neg) begin
         r.ovf   = (m > 64'h8000_0000);
         r.value = r.ovf ? S32_MIN : (32'd0 - m[DATA_W-1:0]);
      end else begin
         r.ovf   = (m > 64'h7fff_ffff);
         r.value = r.ovf ? S32_MAX : m[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/fpa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point ALU front stage
// Decodes the operation, forms the simple results, the magnitude product and
// the divider start values, and registers them.
// ----------------------------------------------------------------------------
module fpa_front #(
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT,
   parameter int QUO_W     = 40
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             in_valid,
   output logic                            in_ready,
   input  wire  [fpa_pkg::MODE_W-1:0]      in_mode,
   input  wire  [fpa_pkg::DATA_W-1:0]      in_a,
   input  wire  [fpa_pkg::DATA_W-1:0]      in_b,
   output logic                            out_valid,
   input  wire                             out_ready,
   output logic [QUO_W-1:0]                out_num,
   output logic [fpa_pkg::DATA_W-1:0]      out_den,
   output fpa_pkg::op_type                 out_op
);

   logic signed [fpa_pkg::DATA_W-1:0] a_s;
   logic signed [fpa_pkg::DATA_W-1:0] b_s;
   logic [fpa_pkg::DATA_W-1:0]        mag_a;
   logic [fpa_pkg::DATA_W-1:0]        mag_b;
   logic                              lt;
   logic                              eq;
   logic signed [fpa_pkg::WIDE_W-1:0] wide;
   fpa_pkg::sat_type                  sat;
   fpa_pkg::op_type                   op_in;
   logic                              valid_ff;
   fpa_pkg::op_type                   op_ff;
   logic [QUO_W-1:0]                  num_ff;
   logic [fpa_pkg::DATA_W-1:0]        den_ff;

   assign a_s   = in_a;
   assign b_s   = in_b;
   assign mag_a = in_a[fpa_pkg::DATA_W-1] ? (32'd0 - in_a) : in_a;
   assign mag_b = in_b[fpa_pkg::DATA_W-1] ? (32'd0 - in_b) : in_b;
   assign lt    = (a_s < b_s);
   assign eq    = (in_a == in_b);

   always_comb begin
      case (in_mode)
         fpa_pkg::MODE_ADD:     wide = 48'(a_s) + 48'(b_s);
         fpa_pkg::MODE_SUB:     wide = 48'(a_s) - 48'(b_s);
         fpa_pkg::MODE_INC:     wide = 48'(a_s) + 48'sd1;
         fpa_pkg::MODE_DEC:     wide = 48'(a_s) - 48'sd1;
         fpa_pkg::MODE_FROMINT: wide = 48'(a_s) <<< FRAC_BITS;
         fpa_pkg::MODE_TOINT:   wide = 48'(a_s >>> FRAC_BITS);
         fpa_pkg::MODE_MIN:     wide = lt ? 48'(a_s) : 48'(b_s);
         fpa_pkg::MODE_MAX:     wide = lt ? 48'(b_s) : 48'(a_s);
         fpa_pkg::MODE_DIV: begin
            if (a_s < 0) begin
               wide = fpa_pkg::WIDE_MIN;
            end else begin
               wide = fpa_pkg::WIDE_MAX;
            end
         end
         default:               wide = '0;
      endcase
   end

   assign sat = fpa_pkg::sat_wide(wide);

   always_comb begin
      op_in.mode         = in_mode;
      op_in.simple_value = sat.value;
      op_in.simple_ovf   = sat.ovf;
      op_in.prod_mag     = 64'(mag_a) * 64'(mag_b);
      op_in.prod_neg     = in_a[fpa_pkg::DATA_W-1] ^ in_b[fpa_pkg::DATA_W-1];
      op_in.div_zero     = (in_mode == fpa_pkg::MODE_DIV) && (in_b == '0);
      case (in_mode)
         fpa_pkg::MODE_LT: op_in.compare_true = lt;
         fpa_pkg::MODE_GT: op_in.compare_true = !lt && !eq;
         fpa_pkg::MODE_LE: op_in.compare_true = lt || eq;
         fpa_pkg::MODE_GE: op_in.compare_true = !lt;
         fpa_pkg::MODE_NE: op_in.compare_true = !eq;
         default:          op_in.compare_true = 1'b0;
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         op_ff  <= op_in;
         num_ff <= QUO_W'(mag_a) << FRAC_BITS;
         den_ff <= mag_b;
      end
   end

   assign out_valid = valid_ff;
   assign out_op    = op_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;

endmodule
`default_nettype wire

// ===== rtl/fpa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point ALU divider pipeline
// Restoring division of the magnitudes, a fixed number of quotient bits per
// register stage, with the operation record carried alongside.
// ----------------------------------------------------------------------------
module fpa_div #(
   parameter int QUO_W = 40
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  wire  [QUO_W-1:0]            in_num,
   input  wire  [fpa_pkg::DATA_W-1:0]  in_den,
   input  wire  fpa_pkg::op_type       in_op,
   output logic                        out_valid,
   input  wire                         out_ready,
   output logic [QUO_W-1:0]            out_quo,
   output logic [fpa_pkg::DATA_W-1:0]  out_rem,
   output logic [fpa_pkg::DATA_W-1:0]  out_den,
   output fpa_pkg::op_type             out_op
);

   localparam int STAGES = QUO_W / fpa_pkg::DIV_STEPS;

   logic                       valid_ff [STAGES];
   logic [QUO_W-1:0]           n_ff     [STAGES];
   logic [fpa_pkg::DATA_W-1:0] rem_ff   [STAGES];
   logic [fpa_pkg::DATA_W-1:0] den_ff   [STAGES];
   fpa_pkg::op_type            op_ff    [STAGES];
   logic                       rdy      [STAGES+1];

   assign rdy[STAGES] = out_ready;
   assign in_ready    = rdy[0];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic                       v_src;
      logic [QUO_W-1:0]           n_src;
      logic [fpa_pkg::DATA_W-1:0] rem_src;
      logic [fpa_pkg::DATA_W-1:0] den_src;
      fpa_pkg::op_type            op_src;
      logic [QUO_W-1:0]           n_in;
      logic [fpa_pkg::DATA_W-1:0] rem_in;

      if (s == 0) begin : g_first
         assign v_src   = in_valid;
         assign n_src   = in_num;
         assign rem_src = '0;
         assign den_src = in_den;
         assign op_src  = in_op;
      end else begin : g_next
         assign v_src   = valid_ff[s-1];
         assign n_src   = n_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign op_src  = op_ff[s-1];
      end

      assign rdy[s] = !valid_ff[s] || rdy[s+1];

      always_comb begin
         logic [fpa_pkg::DATA_W:0]   t;
         logic [fpa_pkg::DATA_W-1:0] r;
         logic [QUO_W-1:0]           n;
         logic                       q;
         r = rem_src;
         n = n_src;
         for (int k = 0; k < fpa_pkg::DIV_STEPS; k++) begin
            t = {r, n[QUO_W-1]};
            q = (t >= {1'b0, den_src});
            if (q) begin
               r = 32'(t - {1'b0, den_src});
            end else begin
               r = t[fpa_pkg::DATA_W-1:0];
            end
            n = {n[QUO_W-2:0], q};
         end
         rem_in = r;
         n_in   = n;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            valid_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            n_ff[s]   <= n_in;
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_src;
            op_ff[s]  <= op_src;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quo   = n_ff[STAGES-1];
   assign out_rem   = rem_ff[STAGES-1];
   assign out_den   = den_ff[STAGES-1];
   assign out_op    = op_ff[STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/fpa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point ALU output stage
// Rounds the product and the quotient, saturates them and selects the result
// into the output register.
// ----------------------------------------------------------------------------
module fpa_back #(
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT,
   parameter int QUO_W     = 40
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  wire  [QUO_W-1:0]            in_quo,
   input  wire  [fpa_pkg::DATA_W-1:0]  in_rem,
   input  wire  [fpa_pkg::DATA_W-1:0]  in_den,
   input  wire  fpa_pkg::op_type       in_op,
   output logic                        out_valid,
   input  wire                         out_ready,
   output fpa_pkg::result_type         out_result
);

   localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

   logic [63:0]          prod_round;
   logic                 round_up;
   logic [QUO_W:0]       quo_round;
   fpa_pkg::sat_type     mul_sat;
   fpa_pkg::sat_type     div_sat;
   fpa_pkg::result_type  result_in;
   fpa_pkg::result_type  result_ff;
   logic                 valid_ff;

   assign prod_round = (in_op.prod_mag + HALF) >> FRAC_BITS;
   assign round_up   = ({in_rem, 1'b0} >= {1'b0, in_den});
   assign quo_round  = (QUO_W+1)'(in_quo) + (QUO_W+1)'(round_up);
   assign mul_sat    = fpa_pkg::sat_mag(prod_round, in_op.prod_neg);
   assign div_sat    = fpa_pkg::sat_mag(64'(quo_round), in_op.prod_neg);

   always_comb begin
      result_in.compare_true = in_op.compare_true;
      case (in_op.mode)
         fpa_pkg::MODE_MUL: begin
            result_in.result_value = mul_sat.value;
            result_in.error_code   = mul_sat.ovf ? fpa_pkg::ERR_OVF : fpa_pkg::ERR_NONE;
         end
         fpa_pkg::MODE_DIV: begin
            if (in_op.div_zero) begin
               result_in.result_value = in_op.simple_value;
               result_in.error_code   = fpa_pkg::ERR_DIV0;
            end else begin
               result_in.result_value = div_sat.value;
               result_in.error_code   = div_sat.ovf ? fpa_pkg::ERR_OVF : fpa_pkg::ERR_NONE;
            end
         end
         default: begin
            result_in.result_value = in_op.simple_value;
            result_in.error_code   = in_op.simple_ovf ? fpa_pkg::ERR_OVF : fpa_pkg::ERR_NONE;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule
`default_nettype wire

// ===== rtl/fixed_point_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A transfer in passes the front register, the divider stages and the output register
// on its way to the result; the divider pipeline sets the depth.
// Throughput is one operation per cycle; every stage holds under back-pressure
// and empty stages fill while the output waits.
// A synchronous reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Signed 32-bit fixed-point arithmetic, comparison and conversion, with
// saturation, rounded multiply and divide.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,  // operand_a [31:0], operand_b [63:32]
   input  wire  [3:0]  req_tuser,  // mode [3:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata   // result_value [31:0], compare_true [32],
                                   // error_code [34:33], zero [39:35]
);

   localparam int QUO_W = ((fpa_pkg::DATA_W + FRAC_BITS + fpa_pkg::DIV_STEPS - 1)
                           / fpa_pkg::DIV_STEPS) * fpa_pkg::DIV_STEPS;

   logic                        front_valid;
   logic                        front_ready;
   logic [QUO_W-1:0]            front_num;
   logic [fpa_pkg::DATA_W-1:0]  front_den;
   fpa_pkg::op_type             front_op;
   logic                        div_valid;
   logic                        div_ready;
   logic [QUO_W-1:0]            div_quo;
   logic [fpa_pkg::DATA_W-1:0]  div_rem;
   logic [fpa_pkg::DATA_W-1:0]  div_den;
   fpa_pkg::op_type             div_op;
   fpa_pkg::result_type         result;

   fpa_front #(
      .FRAC_BITS (FRAC_BITS),
      .QUO_W     (QUO_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_mode   (req_tuser),
      .in_a      (req_tdata[31:0]),
      .in_b      (req_tdata[63:32]),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_num   (front_num),
      .out_den   (front_den),
      .out_op    (front_op)
   );

   fpa_div #(
      .QUO_W (QUO_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_num    (front_num),
      .in_den    (front_den),
      .in_op     (front_op),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_quo   (div_quo),
      .out_rem   (div_rem),
      .out_den   (div_den),
      .out_op    (div_op)
   );

   fpa_back #(
      .FRAC_BITS (FRAC_BITS),
      .QUO_W     (QUO_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_ready   (div_ready),
      .in_quo     (div_quo),
      .in_rem     (div_rem),
      .in_den     (div_den),
      .in_op      (div_op),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {5'd0, result};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (result.error_code == fpa_pkg::ERR_DIV0) |->
         (result.result_value == fpa_pkg::S32_MAX) ||
         (result.result_value == fpa_pkg::S32_MIN))
      else $error("Divide by zero result is not saturated.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (result.error_code == fpa_pkg::ERR_OVF) |->
         (result.result_value == fpa_pkg::S32_MAX) ||
         (result.result_value == fpa_pkg::S32_MIN))
      else $error("Overflow result is not saturated.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result.compare_true |->
         (result.result_value == '0) && (result.error_code == fpa_pkg::ERR_NONE))
      else $error("Comparison transfer carries a value or an error.");

endmodule
`default_nettype wire

// ===== tb/fixed_point_alu_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives directed and random operations through the request stream with
// random gaps and stalls, predicts each result in Q23.8 arithmetic and checks
// the value, compare and error fields of each response in order.
// ----------------------------------------------------------------------------
module fixed_point_alu_tb;

   localparam int FRAC = 8;

   typedef struct {
      logic [3:0]  mode;
      logic [31:0] op_a;
      logic [31:0] op_b;
   } alu_op_type;

   typedef struct {
      logic [31:0] value;
      logic        cmp;
      logic [1:0]  err;
   } alu_res_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   alu_op_type  pending_ops[$];
   alu_res_type expected_results[$];
   int          mismatch_count = 0;
   int          result_count = 0;
   int          sent_count = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   logic        hold_sender;
   logic        req_tready_seen = 1'b0;

   fixed_point_alu #(.FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic alu_res_type saturate(input logic signed [63:0] v,
                                            input logic [1:0] err_in);
      alu_res_type r;
      r.cmp = 1'b0;
      r.err = err_in;
      if (v > 64'sd2147483647) begin
         r.value = fpa_pkg::S32_MAX;
         r.err   = fpa_pkg::ERR_OVF;
      end else if (v < -64'sd2147483648) begin
         r.value = fpa_pkg::S32_MIN;
         r.err   = fpa_pkg::ERR_OVF;
      end else begin
         r.value = v[31:0];
      end
      return r;
   endfunction

   function automatic alu_res_type predict_alu(input alu_op_type op);
      alu_res_type r;
      logic signed [63:0] a, b, p, signed_mag;
      logic [63:0] mag, num, den;
      logic neg;
      a = {{32{op.op_a[31]}}, op.op_a};
      b = {{32{op.op_b[31]}}, op.op_b};
      r.value = '0;
      r.cmp   = 1'b0;
      r.err   = fpa_pkg::ERR_NONE;
      case (op.mode)
         fpa_pkg::MODE_ADD: r = saturate(a + b, fpa_pkg::ERR_NONE);
         fpa_pkg::MODE_SUB: r = saturate(a - b, fpa_pkg::ERR_NONE);
         fpa_pkg::MODE_MUL: begin
            p   = a * b;
            neg = p < 0;
            mag = neg ? -p : p;
            mag = (mag + ((64'd1 << FRAC) >> 1)) >> FRAC;
            signed_mag = neg ? -$signed(mag) : $signed(mag);
            r = saturate(signed_mag, fpa_pkg::ERR_NONE);
         end
         fpa_pkg::MODE_DIV: begin
            if (b == 0) begin
               r.value = (a < 0) ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
               r.err   = fpa_pkg::ERR_DIV0;
            end else begin
               num = (a < 0 ? -a : a) << FRAC;
               den = b < 0 ? -b : b;
               mag = (2 * num + den) / (2 * den);
               neg = (a < 0) != (b < 0);
               signed_mag = neg ? -$signed(mag) : $signed(mag);
               r = saturate(signed_mag, fpa_pkg::ERR_NONE);
            end
         end
         fpa_pkg::MODE_LT: r.cmp = a < b;
         fpa_pkg::MODE_GT: r.cmp = a > b;
         fpa_pkg::MODE_LE: r.cmp = a <= b;
         fpa_pkg::MODE_GE: r.cmp = a >= b;
         fpa_pkg::MODE_NE: r.cmp = a != b;
         fpa_pkg::MODE_MIN: r.value = (a < b) ? op.op_a : op.op_b;
         fpa_pkg::MODE_MAX: r.value = (a > b) ? op.op_a : op.op_b;
         fpa_pkg::MODE_INC: r = saturate(a + 1, fpa_pkg::ERR_NONE);
         fpa_pkg::MODE_DEC: r = saturate(a - 1, fpa_pkg::ERR_NONE);
         fpa_pkg::MODE_TOINT: r.value = $unsigned($signed(op.op_a) >>> FRAC);
         fpa_pkg::MODE_FROMINT: r = saturate(a * (64'sd1 << FRAC), fpa_pkg::ERR_NONE);
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return fpa_pkg::S32_MAX;
         1: return fpa_pkg::S32_MIN;
         2: return 32'd0;
         3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd1;
         4: return 32'(int'($urandom_range(0, 4000)) - 2000);
         5: return 32'(int'($urandom_range(0, 400000)) - 200000);
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 2) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic queue_op(input logic [3:0] mode, input logic [31:0] a,
                           input logic [31:0] b);
      alu_op_type op;
      op.mode = mode;
      op.op_a = a;
      op.op_b = b;
      pending_ops.push_back(op);
   endtask

   // Driver: presents the head of the pending queue with random gaps and stalls the response side at random.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready_seen) begin
            sent_count <= sent_count + 1;
         end
         if ((req_tvalid && !req_tready_seen) || hold_sender) begin
         end else if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_ops[0].mode;
            req_tdata  <= {pending_ops[0].op_b, pending_ops[0].op_a};
            expected_results.push_back(predict_alu(pending_ops[0]));
            void'(pending_ops.pop_front());
            gap_left   <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
         if (hold_sender && req_tvalid && req_tready_seen) req_tvalid <= 1'b0;
         rsp_tready <= (stall_left == 0);
         stall_left <= (stall_left > 0) ? stall_left - 1 : pick_gap();
      end
   end

   // Monitor: records request acceptance and checks each response transfer.
   always @(posedge clock) begin
      alu_res_type exp_r;
      req_tready_seen <= req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count <= result_count + 1;
         if (expected_results.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) $display("Unexpected result %h", rsp_tdata);
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_tdata[31:0] !== exp_r.value || rsp_tdata[32] !== exp_r.cmp
                || rsp_tdata[34:33] !== exp_r.err) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("Result %0d: expected value %h cmp %b err %0d, got %h %b %0d",
                           result_count, exp_r.value, exp_r.cmp, exp_r.err,
                           rsp_tdata[31:0], rsp_tdata[32], rsp_tdata[34:33]);
            end
         end
      end
   end

   initial begin
      logic [3:0] m;
      hold_sender = 1'b0;
      for (int i = 0; i <= 14; i++) begin
         m = 4'(i);
         queue_op(m, fpa_pkg::S32_MAX, fpa_pkg::S32_MAX);
         if (i < 9) queue_op(m, fpa_pkg::S32_MIN, 32'hffff_ffff);
      end
      queue_op(fpa_pkg::MODE_DIV, 32'd5, 32'd0);
      queue_op(fpa_pkg::MODE_DIV, 32'hffff_fffb, 32'd0);
      queue_op(fpa_pkg::MODE_MUL, 32'hffff_ff80, 32'd1);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 650; i++) begin
         queue_op($urandom_range(0, 9) == 0 ? 4'($urandom_range(0, 15))
                  : 4'($urandom_range(0, 14)), pick_operand(), pick_operand());
         if (i == 300) begin
            wait (pending_ops.size() == 0);
            hold_sender = 1'b1;
            wait (expected_results.size() == 0 && !req_tvalid);
            hold_sender = 1'b0;
         end
      end
      wait (pending_ops.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (40) @(posedge clock);
      $display("Checked %0d results over all fifteen modes plus the unused code,",
               result_count);
      $display("with saturation, divide by zero and random stalls on both sides.");
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
